>>> rtl/core/pusp_pkg.sv
// Package for the palette update stream parser.
// Holds the parser state type, the command and status structs passed between
// controller and datapath, and the result codes. It depends on nothing.
`timescale 1ns / 1ps

package pusp_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Upper eleven bits of an address inside the palette window at 3F00h.
  localparam logic [10:0] PAL_WINDOW_TAG = 11'h1F8;
  localparam logic [15:0] STEP_WIDE      = 16'd32;
  localparam logic [15:0] STEP_NARROW    = 16'd1;
  localparam logic [6:0]  COUNT_FULL     = 7'd64;

  typedef enum logic [2:0] {
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_CTRL,
    ST_VALUE,
    ST_DATA,
    ST_DRAIN,
    ST_REPEAT,
    ST_TRUNC
  } state_t;

  typedef struct packed {
    logic       load_hi;
    logic       load_lo;
    logic       load_ctrl;
    logic       hold_value;
    logic       advance;
    logic       src_hold;
    logic       clear_remaining;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic in_window;
    logic more_writes;
    logic rem_one;
    logic eos_hold;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/palette_update_stream_parser.sv
// Palette update stream parser. Results appear in the cycle after the byte transfer that
// causes them. A repeat value byte is followed by one step per unit of its count (1 to
// 64), one step per cycle while the output is free, each writing out if in the window,
// and a truncation after a repeat byte or an in-window data write takes one more step.
// The input stalls during those steps and while a result waits in a stalled output register.
// Synchronous reset returns the parser to awaiting an address high byte and empties output.
`timescale 1ns / 1ps

module palette_update_stream_parser import pusp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [4:0] pal_index,
  output logic [7:0] pal_value,
  output logic       last
);

  cmd_t    cmd;
  status_t status;

  pusp_controller u_controller (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_bit7     (data_byte[7]),
    .byte_bit6     (data_byte[6]),
    .end_of_stream (end_of_stream),
    .status        (status),
    .byte_stall    (byte_stall),
    .cmd           (cmd)
  );

  pusp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .result_stall  (result_stall),
    .status        (status),
    .result_valid  (result_valid),
    .kind          (kind),
    .pal_index     (pal_index),
    .pal_value     (pal_value),
    .last          (last)
  );

endmodule

>>> rtl/core/pusp_datapath.sv
// Datapath of the palette update stream parser: address, step and count
// registers, the held repeat value and the result register.
// Depends on pusp_pkg.
`timescale 1ns / 1ps

module pusp_datapath import pusp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       result_stall,
  output status_t    status,
  output logic       result_valid,
  output logic [1:0] kind,
  output logic [4:0] pal_index,
  output logic [7:0] pal_value,
  output logic       last
);

  logic [15:0] target_address;
  logic        step_by_32;
  logic [6:0]  remaining;
  logic [7:0]  value_hold;
  logic        eos_hold;
  logic [7:0]  write_value;
  logic [15:0] step_amount;

  assign write_value = cmd.src_hold ? value_hold : data_byte;
  assign step_amount = step_by_32 ? STEP_WIDE : STEP_NARROW;

  assign status.in_window   = (target_address[15:5] == PAL_WINDOW_TAG);
  assign status.more_writes = !step_by_32 && (remaining > 7'd1) &&
                              (target_address[4:0] != 5'h1F);
  assign status.rem_one     = (remaining == 7'd1);
  assign status.eos_hold    = eos_hold;
  assign status.out_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
      step_by_32     <= 1'b0;
      remaining      <= '0;
      eos_hold       <= 1'b0;
    end else begin
      if (cmd.load_hi) begin
        target_address <= {data_byte, 8'h00};
      end else if (cmd.load_lo) begin
        target_address <= {target_address[15:8], data_byte};
      end else if (cmd.advance) begin
        target_address <= target_address + step_amount;
      end
      if (cmd.load_ctrl) begin
        step_by_32 <= data_byte[7];
      end
      if (cmd.clear_remaining) begin
        remaining <= '0;
      end else if (cmd.load_ctrl) begin
        remaining <= (data_byte[5:0] == 6'd0) ? COUNT_FULL : {1'b0, data_byte[5:0]};
      end else if (cmd.advance && remaining != 7'd0) begin
        remaining <= remaining - 7'd1;
      end
      if (cmd.hold_value) begin
        eos_hold <= end_of_stream;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_value) begin
      value_hold <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind <= cmd.emit_kind;
      last <= cmd.emit_last;
      if (cmd.emit_kind == KIND_WRITE) begin
        pal_index <= target_address[4:0];
        pal_value <= write_value;
      end else begin
        pal_index <= '0;
        pal_value <= '0;
      end
    end
  end

endmodule

>>> rtl/core/pusp_controller.sv
// Controller of the palette update stream parser: tracks the record phase,
// sequences repeat writes and truncation results, and drives the input stall.
// Depends on pusp_pkg.
`timescale 1ns / 1ps

module pusp_controller import pusp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_valid,
  input  logic    byte_bit7,
  input  logic    byte_bit6,
  input  logic    end_of_stream,
  input  status_t status,
  output logic    byte_stall,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   byte_state;
  logic   accept;

  always_comb begin
    unique case (state)
      ST_ADDR_HI, ST_ADDR_LO, ST_CTRL, ST_VALUE, ST_DATA, ST_DRAIN: byte_state = 1'b1;
      default: byte_state = 1'b0;
    endcase
  end

  assign byte_stall = !(byte_state && status.out_free);
  assign accept     = byte_valid && byte_state && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ADDR_HI;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ADDR_HI: begin
        if (accept) begin
          if (byte_bit7) begin
            state_next = end_of_stream ? ST_ADDR_HI : ST_DRAIN;
          end else begin
            state_next = end_of_stream ? ST_ADDR_HI : ST_ADDR_LO;
          end
        end
      end
      ST_ADDR_LO: begin
        if (accept) begin
          state_next = end_of_stream ? ST_ADDR_HI : ST_CTRL;
        end
      end
      ST_CTRL: begin
        if (accept) begin
          if (end_of_stream) begin
            state_next = ST_ADDR_HI;
          end else begin
            state_next = byte_bit6 ? ST_VALUE : ST_DATA;
          end
        end
      end
      ST_VALUE: begin
        if (accept) begin
          state_next = ST_REPEAT;
        end
      end
      ST_DATA: begin
        if (accept) begin
          if (end_of_stream) begin
            state_next = status.in_window ? ST_TRUNC : ST_ADDR_HI;
          end else if (status.rem_one) begin
            state_next = ST_ADDR_HI;
          end
        end
      end
      ST_DRAIN: begin
        if (accept && end_of_stream) begin
          state_next = ST_ADDR_HI;
        end
      end
      ST_REPEAT: begin
        if (status.out_free && status.rem_one) begin
          state_next = status.eos_hold ? ST_TRUNC : ST_ADDR_HI;
        end
      end
      ST_TRUNC: begin
        if (status.out_free) begin
          state_next = ST_ADDR_HI;
        end
      end
      default: state_next = ST_ADDR_HI;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_kind = KIND_WRITE;
    unique case (state)
      ST_ADDR_HI: begin
        if (accept) begin
          if (byte_bit7) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.load_hi = 1'b1;
            if (end_of_stream) begin
              cmd.emit            = 1'b1;
              cmd.emit_kind       = KIND_TRUNC;
              cmd.emit_last       = 1'b1;
              cmd.clear_remaining = 1'b1;
            end
          end
        end
      end
      ST_ADDR_LO, ST_CTRL: begin
        if (accept) begin
          cmd.load_lo   = (state == ST_ADDR_LO);
          cmd.load_ctrl = (state == ST_CTRL);
          if (end_of_stream) begin
            cmd.emit            = 1'b1;
            cmd.emit_kind       = KIND_TRUNC;
            cmd.emit_last       = 1'b1;
            cmd.clear_remaining = 1'b1;
          end
        end
      end
      ST_VALUE: begin
        cmd.hold_value = accept;
      end
      ST_DATA: begin
        if (accept) begin
          cmd.advance = 1'b1;
          if (status.in_window) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_WRITE;
            cmd.emit_last = !end_of_stream;
          end else if (end_of_stream) begin
            cmd.emit            = 1'b1;
            cmd.emit_kind       = KIND_TRUNC;
            cmd.emit_last       = 1'b1;
            cmd.clear_remaining = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
      end
      ST_REPEAT: begin
        if (status.out_free) begin
          cmd.advance  = 1'b1;
          cmd.src_hold = 1'b1;
          if (status.in_window) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_WRITE;
            cmd.emit_last = !status.eos_hold && !status.more_writes;
          end
        end
      end
      ST_TRUNC: begin
        if (status.out_free) begin
          cmd.emit            = 1'b1;
          cmd.emit_kind       = KIND_TRUNC;
          cmd.emit_last       = 1'b1;
          cmd.clear_remaining = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
